/* hw/rtl/first_fit_slot_allocator_unit_macros.svh */
// Assertion macros shared by the allocator RTL
`ifndef FIRST_FIT_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define FFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa assertion failed");
// Next-cycle implication, checked outside reset
`define FFSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa assertion failed");
`else
`define FFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FFSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/ffsa_pkg.sv */
package ffsa_pkg;

    localparam int IDX_W  = 20;
    localparam int SPT_W  = 7;
    localparam int TC_W   = 7;
    localparam int ROFF_W = 21;
    localparam int TILE_W = 6;
    localparam int OFF_W  = 22;
    localparam int CIDX_W = 2;

    localparam logic [IDX_W-1:0] NEVER_MARK = '1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SLOTS_PER_TILE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TILE_COUNT      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RESERVED_OFFSET = 2'd2;

    // Request travelling down the slot chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  write_index;
        logic              port;
        logic [IDX_W-1:0]  free_after_port0;
        logic [IDX_W-1:0]  free_after_port1;
        logic [SPT_W-1:0]  pos;       // slot position inside the tile of this cell
        logic [TC_W-1:0]   tile;      // tile of this cell, saturating
        logic [OFF_W-1:0]  run_off;   // pos times entry size
        logic [TILE_W-1:0] hit_tile;
        logic [OFF_W-1:0]  hit_off;
    } ffsa_pkt_t;

endpackage

/* hw/rtl/ffsa_cell.sv */
module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter int PORT_COUNT  = 2,
    parameter int ENTRY_BYTES = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SPT_W-1:0] slots_per_tile,
    input  logic [TC_W-1:0]  tile_count,
    input  ffsa_pkt_t        pkt_in,
    output ffsa_pkt_t        pkt_out
);

    logic [IDX_W-1:0] s0_reg, s0_next;
    logic [IDX_W-1:0] s1_reg, s1_next;
    ffsa_pkt_t        pkt_reg, pkt_next;

    logic [IDX_W-1:0] stored;
    logic             port_ok;
    logic             in_range;
    logic             take;
    logic [SPT_W:0]   pos_inc;

    // Qualify this slot for the passing transaction
    always_comb
    begin
        stored   = pkt_in.port ? s1_reg : s0_reg;
        port_ok  = (PORT_COUNT == 2) || (pkt_in.port == 1'b0);
        in_range = (slots_per_tile != '0) && (pkt_in.tile < tile_count);
        take     = pkt_in.valid && !pkt_in.hit && port_ok && in_range
                   && (stored != NEVER_MARK) && !(pkt_in.write_index < stored);
    end

    // Claim the slot and advance the position counters for the next cell
    always_comb
    begin
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        pkt_next = pkt_in;
        pos_inc  = {1'b0, pkt_in.pos} + 1'b1;
        if (take)
        begin
            s0_next          = pkt_in.free_after_port0;
            s1_next          = pkt_in.free_after_port1;
            pkt_next.hit     = 1'b1;
            pkt_next.hit_tile = pkt_in.tile[TILE_W-1:0];
            pkt_next.hit_off = pkt_in.run_off;
        end
        if (pos_inc == {1'b0, slots_per_tile})
        begin
            pkt_next.pos     = '0;
            pkt_next.run_off = '0;
            if (pkt_in.tile != '1)
            begin
                pkt_next.tile = pkt_in.tile + 1'b1;
            end
        end
        else
        begin
            pkt_next.pos     = pos_inc[SPT_W-1:0];
            pkt_next.run_off = pkt_in.run_off + OFF_W'(ENTRY_BYTES);
        end
    end

    // Hold slot state; every slot starts free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
        end
    end

    // Hand the transaction to the neighbour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

/* hw/rtl/first_fit_slot_allocator_unit.sv */
// First-fit slot allocator.
// Request channel: drive start with write_index, port and the two free-after
// indices; the request is taken at a clock edge where start is high and busy
// is low. busy is high only while a configuration write is being offered.
// Each request walks a chain of MAX_SLOTS slot cells, one cell per cycle; the
// first cell whose stored index for the port is not above write_index claims
// it and records the new free-after indices. A request behind it follows one
// cell later and so sees every earlier claim, so one request may enter each
// cycle while busy is low. The result strobe comes from the output register
// behind the last cell; the first cell captures at the accepting edge.
// Result channel: result_valid is high for exactly one cycle per request with
// found, tile and byte_offset; tile and byte_offset are zero when not found.
// The receiver cannot stall, so results are never held back.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// high only when no request is in flight. Index 3 is accepted and ignored.
// Reset marks every slot free and sets one slot per tile, one tile, offset 0.
`include "first_fit_slot_allocator_unit_macros.svh"

module first_fit_slot_allocator_unit
    import ffsa_pkg::*;
#(
    parameter int MAX_SLOTS   = 64,
    parameter int PORT_COUNT  = 2,
    parameter int ENTRY_BYTES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IDX_W-1:0]  write_index,
    input  logic              port,
    input  logic [IDX_W-1:0]  free_after_port0,
    input  logic [IDX_W-1:0]  free_after_port1,
    output logic              result_valid,
    output logic              found,
    output logic [TILE_W-1:0] tile,
    output logic [OFF_W-1:0]  byte_offset,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [ROFF_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 2) + 1;

    logic [SPT_W-1:0]  spt_reg;
    logic [TC_W-1:0]   tc_reg;
    logic [ROFF_W-1:0] roff_reg;
    logic [CNT_W-1:0]  inflight_reg, inflight_next;
    logic              rv_reg;
    logic              found_reg;
    logic [TILE_W-1:0] tile_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              accept;
    logic              cfg_wr;

    ffsa_pkt_t chain [MAX_SLOTS+1];
    ffsa_pkt_t head;
    ffsa_pkt_t tail;

    assign busy      = cfg_valid;
    assign accept    = start && !busy;
    assign cfg_ready = (inflight_reg == '0);
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg  <= SPT_W'(1);
            tc_reg   <= TC_W'(1);
            roff_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_SLOTS_PER_TILE:  spt_reg  <= cfg_data[SPT_W-1:0];
                CFG_TILE_COUNT:      tc_reg   <= cfg_data[TC_W-1:0];
                CFG_RESERVED_OFFSET: roff_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Build the transaction entering the first cell
    always_comb
    begin
        head                  = '0;
        head.valid            = accept;
        head.write_index      = write_index;
        head.port             = port;
        head.free_after_port0 = free_after_port0;
        head.free_after_port1 = free_after_port1;
    end

    assign chain[0] = head;

    // Slot chain
    for (genvar k = 0; k < MAX_SLOTS; k++)
    begin : g_cell
        ffsa_cell #(
            .PORT_COUNT  (PORT_COUNT),
            .ENTRY_BYTES (ENTRY_BYTES)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .slots_per_tile (spt_reg),
            .tile_count     (tc_reg),
            .pkt_in         (chain[k]),
            .pkt_out        (chain[k+1])
        );
    end

    assign tail = chain[MAX_SLOTS];

    // Register the result; zero the fields when nothing was found
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= tail.hit;
        tile_reg  <= tail.hit ? tail.hit_tile : '0;
        off_reg   <= tail.hit ? (OFF_W'(roff_reg) + tail.hit_off) : '0;
    end

    // Count transactions in flight
    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept && !rv_reg)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!accept && rv_reg)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    assign result_valid = rv_reg;
    assign found        = found_reg;
    assign tile         = tile_reg;
    assign byte_offset  = off_reg;

    `FFSA_ASSERT_IMP(a_notfound_zero, clk, rst_n, result_valid && !found, {tile, byte_offset} == '0)
    `FFSA_ASSERT_IMP(a_result_in_flight, clk, rst_n, result_valid, inflight_reg != '0)
    `FFSA_ASSERT_IMP(a_cfg_excludes_req, clk, rst_n, cfg_wr, !accept)
    `FFSA_ASSERT_NXT(a_accept_counted, clk, rst_n, accept && !result_valid, inflight_reg != '0)

endmodule

/* tb/slot_claim_checker.sv */
module slot_claim_checker
    import ffsa_pkg::*;
#(
    parameter int MAX_SLOTS   = 64,
    parameter int PORT_COUNT  = 2,
    parameter int ENTRY_BYTES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [IDX_W-1:0]  write_index,
    input  logic              port,
    input  logic [IDX_W-1:0]  free_after_port0,
    input  logic [IDX_W-1:0]  free_after_port1,
    input  logic              result_valid,
    input  logic              found,
    input  logic [TILE_W-1:0] tile,
    input  logic [OFF_W-1:0]  byte_offset,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [ROFF_W-1:0] cfg_data,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              found;
        logic [TILE_W-1:0] tile;
        logic [OFF_W-1:0]  byte_offset;
    } slot_grant_t;

    // Own copy of the slot table and the layout registers
    logic [IDX_W-1:0]  free_from_p0 [MAX_SLOTS];
    logic [IDX_W-1:0]  free_from_p1 [MAX_SLOTS];
    logic [SPT_W-1:0]  slots_per_tile;
    logic [TC_W-1:0]   tile_count;
    logic [ROFF_W-1:0] reserved_offset;

    slot_grant_t grants_due [$];

    // Take the lowest free slot for the port and record its new free-after indices
    function automatic slot_grant_t claim_slot(logic [IDX_W-1:0] widx, logic req_port,
                                               logic [IDX_W-1:0] fa0, logic [IDX_W-1:0] fa1);
        slot_grant_t      grant;
        int               spt;
        int               limit;
        logic [IDX_W-1:0] held;
        grant = '0;
        spt   = int'(slots_per_tile);
        limit = spt * int'(tile_count);
        if (limit > MAX_SLOTS)
            limit = MAX_SLOTS;
        if (int'(req_port) >= PORT_COUNT || spt == 0)
            return grant;
        for (int s = 0; s < limit; s++)
        begin
            held = req_port ? free_from_p1[s] : free_from_p0[s];
            if (held != NEVER_MARK && widx >= held)
            begin
                free_from_p0[s]   = fa0;
                free_from_p1[s]   = fa1;
                grant.found       = 1'b1;
                grant.tile        = TILE_W'(s / spt);
                grant.byte_offset = OFF_W'(int'(reserved_offset) + (s % spt) * ENTRY_BYTES);
                return grant;
            end
        end
        return grant;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_grant_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                free_from_p0[s] = '0;
                free_from_p1[s] = '0;
            end
            slots_per_tile  = SPT_W'(1);
            tile_count      = TC_W'(1);
            reserved_offset = '0;
            grants_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // Track layout register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SLOTS_PER_TILE:  slots_per_tile  = cfg_data[SPT_W-1:0];
                    CFG_TILE_COUNT:      tile_count      = cfg_data[TC_W-1:0];
                    CFG_RESERVED_OFFSET: reserved_offset = cfg_data;
                    default: ;
                endcase
            end

            // Predict each accepted request in acceptance order
            if (start && !busy)
                grants_due.push_back(claim_slot(write_index, port,
                                                free_after_port0, free_after_port1));

            // Compare each result with the oldest prediction
            if (result_valid)
            begin
                if (grants_due.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0d tile=%0d byte_offset=%0d",
                             $time, found, tile, byte_offset);
                    errors++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d, got %0d", $time, want.found, found);
                        errors++;
                    end
                    if (tile !== want.tile)
                    begin
                        $display("%0t: tile expected %0d, got %0d", $time, want.tile, tile);
                        errors++;
                    end
                    if (byte_offset !== want.byte_offset)
                    begin
                        $display("%0t: byte_offset expected %0d, got %0d",
                                 $time, want.byte_offset, byte_offset);
                        errors++;
                    end
                end
            end
            pending = grants_due.size();
        end
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    import ffsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS   = 64;
    localparam int PORT_COUNT  = 2;
    localparam int ENTRY_BYTES = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ROUND_ITEMS = 125;

    localparam logic [IDX_W-1:0]  WIDX_MAX   = 20'd1048574;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [IDX_W-1:0]  write_index;
    logic              port;
    logic [IDX_W-1:0]  free_after_port0;
    logic [IDX_W-1:0]  free_after_port1;
    logic              result_valid;
    logic              found;
    logic [TILE_W-1:0] tile;
    logic [OFF_W-1:0]  byte_offset;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [ROFF_W-1:0] cfg_data;

    int          errors;
    int          pending;
    int          cycles;
    bit          steady;
    int unsigned order_idx;

    first_fit_slot_allocator_unit #(
        .MAX_SLOTS   (MAX_SLOTS),
        .PORT_COUNT  (PORT_COUNT),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_top (.*);

    slot_claim_checker #(
        .MAX_SLOTS   (MAX_SLOTS),
        .PORT_COUNT  (PORT_COUNT),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_checker (.*);

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none in steady rounds
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Free-after index near the running order index, now and then never or zero
    function automatic logic [IDX_W-1:0] pick_free_after(int unsigned base);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 99);
        if (r < 4)
            return NEVER_MARK;
        if (r < 12)
            return '0;
        v = base + $urandom_range(0, 24);
        if (v > int'(WIDX_MAX))
            v = 32'(WIDX_MAX);
        return IDX_W'(v);
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(input logic [IDX_W-1:0] widx, input logic req_port,
                                input logic [IDX_W-1:0] fa0, input logic [IDX_W-1:0] fa1);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start            <= 1'b1;
        write_index      <= widx;
        port             <= req_port;
        free_after_port0 <= fa0;
        free_after_port1 <= fa1;
        do @(posedge clk); while (busy);
    endtask

    // Wait until every outstanding request has produced its result
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [ROFF_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain, then load a new slot layout
    task automatic set_layout(input int spt, input int tiles, input int roff);
        wait_drained();
        write_register(CFG_SLOTS_PER_TILE, ROFF_W'(spt));
        write_register(CFG_TILE_COUNT, ROFF_W'(tiles));
        write_register(CFG_RESERVED_OFFSET, ROFF_W'(roff));
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // Mostly ordered traffic from an advancing index, the rest noise
    task automatic run_traffic(input int count);
        logic [IDX_W-1:0] widx;
        logic [IDX_W-1:0] fa0;
        logic [IDX_W-1:0] fa1;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                order_idx += $urandom_range(0, 3);
                if (order_idx > int'(WIDX_MAX))
                    order_idx = 32'(WIDX_MAX);
                widx = IDX_W'(order_idx);
                fa0  = pick_free_after(order_idx);
                fa1  = pick_free_after(order_idx);
            end
            else
            begin
                widx = IDX_W'($urandom_range(0, int'(WIDX_MAX)));
                fa0  = pick_free_after(order_idx);
                fa1  = pick_free_after(order_idx);
                if ($urandom_range(0, 2) == 0)
                    fa0 = IDX_W'($urandom_range(0, 1048575));
                else if ($urandom_range(0, 2) == 0)
                    fa1 = IDX_W'($urandom_range(0, 1048575));
            end
            send_request(widx, 1'($urandom_range(0, 1)), fa0, fa1);
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        start            = 1'b0;
        write_index      = '0;
        port             = 1'b0;
        free_after_port0 = '0;
        free_after_port1 = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_SLOTS_PER_TILE;
        cfg_data         = '0;
        cycles           = 0;
        steady           = 1'b1;
        order_idx        = $urandom_range(0, 1000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single slot after reset: equal index, never marker on each port, extremes
        send_request('0, 1'b0, 20'd10, NEVER_MARK);
        send_request(20'd9, 1'b0, '0, '0);
        send_request(WIDX_MAX, 1'b1, '0, '0);
        send_request(20'd10, 1'b0, NEVER_MARK, '0);
        send_request(WIDX_MAX, 1'b0, '0, '0);
        send_request('0, 1'b1, '0, NEVER_MARK);
        send_request('0, 1'b0, WIDX_MAX, WIDX_MAX);
        send_request(WIDX_MAX, 1'b0, '0, '0);

        set_layout(1, 1, 0);
        run_traffic(ROUND_ITEMS);

        // Two tiles of four at the top offset: fill in first-fit order, then one too many
        set_layout(4, 2, 2097151);
        steady = 1'b1;
        for (int n = 0; n < 9; n++)
            send_request(IDX_W'(order_idx), 1'b0, IDX_W'(order_idx + 50), IDX_W'(order_idx + 50));
        run_traffic(ROUND_ITEMS);

        set_layout(1, 64, 0);
        run_traffic(ROUND_ITEMS);

        // No slots at all
        set_layout(0, 5, $urandom_range(0, 2097151));
        write_register(CFG_UNUSED, ROFF_W'($urandom_range(0, 2097151)));
        run_traffic(ROUND_ITEMS / 3);

        set_layout(6, 0, $urandom_range(0, 2097151));
        run_traffic(ROUND_ITEMS / 3);

        set_layout(5, 13, $urandom_range(0, 2097151));
        run_traffic(ROUND_ITEMS);

        set_layout(3, 7, $urandom_range(0, 2097151));
        run_traffic(ROUND_ITEMS);

        set_layout(127, 127, $urandom_range(0, 2097151));
        run_traffic(ROUND_ITEMS);

        // Jump near the top of the index range so stale claims free up
        set_layout(64, 64, $urandom_range(0, 2097151));
        order_idx = 1040000;
        run_traffic(ROUND_ITEMS);

        set_layout(8, 8, $urandom_range(0, 2097151));
        run_traffic(ROUND_ITEMS);

        // Drain and allow for stray results
        wait_drained();
        repeat (MAX_SLOTS + 4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_cell.sv
hw/rtl/first_fit_slot_allocator_unit.sv
tb/slot_claim_checker.sv
tb/tb_top.sv
